// File: rtl/epoch_seconds_to_date_defines.svh
// Assertion macros shared by the epoch_seconds_to_date RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef EPOCH_SECONDS_TO_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATE_DEFINES_SVH

// same-cycle implication
`define ESD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esd_pkg.sv
// Shared types, constants and microcode ROM for epoch_seconds_to_date.
// No dependencies.
package esd_pkg;

  localparam int ESD_SECONDS_WIDTH = 32;
  localparam int YEAR_W            = 12;
  localparam int MONTH_W           = 4;
  localparam int DOM_W             = 5;
  localparam int REM_W             = 17;
  localparam int YSEC_W            = 25;
  localparam int MSEC_W            = 22;
  localparam int PC_W              = 3;

  localparam logic [REM_W-1:0]   SEC_PER_DAY  = 17'd86400;
  localparam logic [YSEC_W-1:0]  SEC_PER_YEAR = 25'd31536000;
  localparam logic [YSEC_W-1:0]  SEC_PER_LEAP = 25'd31622400;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1970;
  localparam logic [1:0]         EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]         EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]         EPOCH_MOD400 = 9'd370;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_IDLE  = 3'd0;
  localparam pc_t STEP_YEAR  = 3'd1;
  localparam pc_t STEP_MONTH = 3'd2;
  localparam pc_t STEP_DAY   = 3'd3;
  localparam pc_t STEP_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_IN_VALID,
    C_YEAR_FITS,
    C_MONTH_DONE,
    C_DAY_DONE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    ACT_ALWAYS,
    ACT_TRUE,
    ACT_FALSE
  } act_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    act_t  act;
    pc_t   t_true;
    pc_t   t_false;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic en;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic year_fits;
    logic month_done;
    logic day_done;
    logic out_free;
  } status_t;

  function automatic ucode_t esd_ucode(input pc_t pc);
    ucode_t w;
    case (pc)
      STEP_IDLE:  w = '{OP_LOAD,  C_IN_VALID,   ACT_TRUE,   STEP_YEAR,  STEP_IDLE};
      STEP_YEAR:  w = '{OP_YEAR,  C_YEAR_FITS,  ACT_FALSE,  STEP_MONTH, STEP_YEAR};
      STEP_MONTH: w = '{OP_MONTH, C_MONTH_DONE, ACT_FALSE,  STEP_DAY,   STEP_MONTH};
      STEP_DAY:   w = '{OP_DAY,   C_DAY_DONE,   ACT_FALSE,  STEP_EMIT,  STEP_DAY};
      STEP_EMIT:  w = '{OP_EMIT,  C_OUT_FREE,   ACT_TRUE,   STEP_IDLE,  STEP_EMIT};
      default:    w = '{OP_LOAD,  C_IN_VALID,   ACT_ALWAYS, STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

  // month length in seconds
  function automatic logic [MSEC_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [MSEC_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 22'd2678400;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 22'd2592000;
      default:                                   len = leap ? 22'd2505600 : 22'd2419200;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/esd_channels.sv
// Valid/ready channel interfaces for epoch_seconds_to_date.
// Depends on esd_pkg.
interface esd_in_if import esd_pkg::*; #(
  parameter int W = ESD_SECONDS_WIDTH
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] elapsed_seconds;

  modport source (output valid, output elapsed_seconds, input ready);
  modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

interface esd_out_if import esd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;

  modport source (output valid, output year, output month, output day_of_month,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  output ready);
endinterface

// File: rtl/epoch_seconds_to_date.sv
// Top level: seconds since 1970-01-01 to Gregorian year/month/day.
// Depends on esd_pkg, esd_channels, esd_seq and epoch_seconds_to_date_defines.svh.
//
//   channel  | dir | word
//   in_ch    | in  | elapsed_seconds[SECONDS_WIDTH-1:0]
//   out_ch   | out | year[11:0], month[3:0], day_of_month[4:0]
//
// Years, months and days are each taken off the seconds count one per cycle;
// the year loop dominates.
// Reset: synchronous, active low; clears the step counter and output valid.
// One word in flight; in_ch is taken again as soon as the result is in the
// output register; a stalled out_ch holds the next word at the emit step.
`include "epoch_seconds_to_date_defines.svh"

module epoch_seconds_to_date import esd_pkg::*; #(
  parameter int SECONDS_WIDTH = ESD_SECONDS_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);

  ctrl_t   ctrl;
  status_t sts;

  logic [SECONDS_WIDTH-1:0] sec_r, sec_nxt;
  logic [YEAR_W-1:0]        year_r, year_nxt;
  logic [1:0]               mod4_r, mod4_nxt;
  logic [6:0]               mod100_r, mod100_nxt;
  logic [8:0]               mod400_r, mod400_nxt;
  logic [MONTH_W-1:0]       mon_r, mon_nxt;
  logic [DOM_W-1:0]         dom_r, dom_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]        out_year_r, out_year_nxt;
  logic [MONTH_W-1:0]       out_mon_r, out_mon_nxt;
  logic [DOM_W-1:0]         out_dom_r, out_dom_nxt;

  logic                     leap;
  logic [YSEC_W-1:0]        ylen;
  logic [MSEC_W-1:0]        mlen;

  esd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  always_comb begin
    leap  = (mod400_r == 9'd0) || ((mod4_r == 2'd0) && (mod100_r != 7'd0));
    ylen  = leap ? SEC_PER_LEAP : SEC_PER_YEAR;
    mlen  = month_secs(mon_r, leap);

    sts.in_valid   = in_ch.valid;
    sts.year_fits  = (sec_r < SECONDS_WIDTH'(ylen));
    sts.month_done = (mon_r == 4'd12) || (sec_r < SECONDS_WIDTH'(mlen));
    sts.day_done   = (sec_r < SECONDS_WIDTH'(SEC_PER_DAY));
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    sec_nxt       = sec_r;
    year_nxt      = year_r;
    mod4_nxt      = mod4_r;
    mod100_nxt    = mod100_r;
    mod400_nxt    = mod400_r;
    mon_nxt       = mon_r;
    dom_nxt       = dom_r;
    out_year_nxt  = out_year_r;
    out_mon_nxt   = out_mon_r;
    out_dom_nxt   = out_dom_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (ctrl.en) begin
      case (ctrl.op)
        OP_LOAD: begin
          sec_nxt    = in_ch.elapsed_seconds;
          year_nxt   = EPOCH_YEAR;
          mod4_nxt   = EPOCH_MOD4;
          mod100_nxt = EPOCH_MOD100;
          mod400_nxt = EPOCH_MOD400;
          mon_nxt    = 4'd1;
          dom_nxt    = '0;
        end
        OP_YEAR: begin
          sec_nxt    = sec_r - SECONDS_WIDTH'(ylen);
          year_nxt   = year_r + 1'b1;
          mod4_nxt   = mod4_r + 1'b1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 1'b1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 1'b1;
        end
        OP_MONTH: begin
          sec_nxt = sec_r - SECONDS_WIDTH'(mlen);
          mon_nxt = mon_r + 1'b1;
        end
        OP_DAY: begin
          sec_nxt = sec_r - SECONDS_WIDTH'(SEC_PER_DAY);
          dom_nxt = dom_r + 1'b1;
        end
        OP_EMIT: begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r;
          out_mon_nxt   = mon_r;
          out_dom_nxt   = dom_r + 1'b1;
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r      <= sec_nxt;
    year_r     <= year_nxt;
    mod4_r     <= mod4_nxt;
    mod100_r   <= mod100_nxt;
    mod400_r   <= mod400_nxt;
    mon_r      <= mon_nxt;
    dom_r      <= dom_nxt;
    out_year_r <= out_year_nxt;
    out_mon_r  <= out_mon_nxt;
    out_dom_r  <= out_dom_nxt;
  end

  assign in_ch.ready         = (ctrl.op == OP_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.year         = out_year_r;
  assign out_ch.month        = out_mon_r;
  assign out_ch.day_of_month = out_dom_r;

  `ESD_ASSERT_NEXT(a_busy_after_load, in_ch.valid && in_ch.ready, !in_ch.ready, "busy load")
  `ESD_ASSERT_NOW(a_mon_rng, ctrl.op == OP_MONTH, (mon_r != '0) && (mon_r <= 4'd12), "bad month")
  `ESD_ASSERT_NOW(a_day_nonzero, out_ch.valid, out_ch.day_of_month != '0, "day of month is zero")
  `ESD_ASSERT_NOW(a_mod4_track, ctrl.op != OP_LOAD, mod4_r == year_r[1:0], "leap count lost year")

endmodule

// File: rtl/esd_seq.sv
// Microcode sequencer: step counter, control ROM, condition select.
// Depends on esd_pkg.
module esd_seq import esd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t sts,
  output ctrl_t   ctrl
);

  pc_t    pc_r, pc_nxt;
  ucode_t uw;
  logic   cond_v;

  always_comb begin
    uw = esd_ucode(pc_r);
    case (uw.cond)
      C_IN_VALID:   cond_v = sts.in_valid;
      C_YEAR_FITS:  cond_v = sts.year_fits;
      C_MONTH_DONE: cond_v = sts.month_done;
      C_DAY_DONE:   cond_v = sts.day_done;
      C_OUT_FREE:   cond_v = sts.out_free;
      default:      cond_v = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.op = uw.op;
    case (uw.act)
      ACT_ALWAYS: ctrl.en = 1'b1;
      ACT_TRUE:   ctrl.en = cond_v;
      ACT_FALSE:  ctrl.en = !cond_v;
      default:    ctrl.en = 1'b0;
    endcase
    pc_nxt = cond_v ? uw.t_true : uw.t_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_date: drives seconds words, predicts each calendar
// date, and compares every result word. Uses esd_pkg, esd_channels and the top RTL.
module testbench import esd_pkg::*;;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned RANDOM_WORDS = 2000;
  localparam int unsigned LAST_DAY = 49709;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
  } date_t;

  class calendar_scoreboard;
    date_t dates_due[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function bit is_leap(int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    static function int unsigned year_days(int unsigned yr);
      return is_leap(yr) ? 366 : 365;
    endfunction

    static function int unsigned month_days(int unsigned yr, int unsigned mo);
      case (mo)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        default:               return is_leap(yr) ? 29 : 28;
      endcase
    endfunction

    function date_t date_of(logic [ESD_SECONDS_WIDTH-1:0] secs);
      int unsigned days, yr, mo;
      date_t d;
      days = secs / 86400;
      yr = 1970;
      mo = 1;
      while (days >= year_days(yr)) begin
        days -= year_days(yr);
        yr++;
      end
      while (mo < 12 && days >= month_days(yr, mo)) begin
        days -= month_days(yr, mo);
        mo++;
      end
      d.year = yr[YEAR_W-1:0];
      d.month = mo[MONTH_W-1:0];
      d.day_of_month = days[DOM_W-1:0] + 1'b1;
      return d;
    endfunction

    function void note_seconds(logic [ESD_SECONDS_WIDTH-1:0] secs);
      dates_due.push_back(date_of(secs));
    endfunction

    function void check_date(logic [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                             logic [DOM_W-1:0] dom);
      date_t want;
      if (dates_due.size() == 0) begin
        $error("unexpected date word %0d-%0d-%0d", year, month, dom);
        errors++;
        return;
      end
      want = dates_due.pop_front();
      if (year !== want.year) begin
        $error("year: expected %0d, got %0d", want.year, year);
        errors++;
      end
      if (month !== want.month) begin
        $error("month: expected %0d, got %0d", want.month, month);
        errors++;
      end
      if (dom !== want.day_of_month) begin
        $error("day_of_month: expected %0d, got %0d", want.day_of_month, dom);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return dates_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  calendar_scoreboard dates;

  esd_in_if #(.W(ESD_SECONDS_WIDTH)) in_ch ();
  esd_out_if out_ch ();

  epoch_seconds_to_date #(.SECONDS_WIDTH(ESD_SECONDS_WIDTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // zero-based day index of the first day of yr-mo
  function automatic int unsigned first_day(int unsigned yr, int unsigned mo);
    int unsigned days;
    days = 0;
    for (int unsigned y = 1970; y < yr; y++) days += calendar_scoreboard::year_days(y);
    for (int unsigned m = 1; m < mo; m++) days += calendar_scoreboard::month_days(yr, m);
    return days;
  endfunction

  function automatic logic [31:0] at_day(int unsigned day, int unsigned tod);
    longint unsigned s;
    s = longint'(day) * 86400 + tod;
    return s[31:0];
  endfunction

  function automatic logic [31:0] random_seconds();
    int unsigned yr, mo, day;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        day = $urandom_range(0, LAST_DAY);
        return at_day(day, $urandom_range(0, 1) ? 86399 : 0);
      end
      2: begin
        yr = $urandom_range(1970, 2105);
        mo = $urandom_range(1, 12);
        day = first_day(yr, mo) + calendar_scoreboard::month_days(yr, mo) - 1;
        return at_day(day, $urandom_range(0, 86399));
      end
      default: begin
        yr = $urandom_range(1970, 2105);
        mo = $urandom_range(1, 12);
        return at_day(first_day(yr, mo), $urandom_range(0, 86399));
      end
    endcase
  endfunction

  task automatic send_seconds(input logic [31:0] secs);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.elapsed_seconds <= secs;
    do @(posedge clk); while (!in_ch.ready);
    dates.note_seconds(secs);
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    int unsigned stall, seen, gap;
    bit held;
    stall = 0;
    seen = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        dates.check_date(out_ch.year, out_ch.month, out_ch.day_of_month);
        seen++;
      end
      if (!held && seen == 40) begin
        held = 1'b1;
        stall = 800;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        gap = idle_len();
        out_ch.ready <= (gap == 0);
        if (gap != 0) stall = gap - 1;
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [31:0] directed[$];
    dates = new();
    steady = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.elapsed_seconds = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(32'd0);
    directed.push_back(32'd86399);
    directed.push_back(32'd86400);
    directed.push_back(at_day(30, 86399));
    directed.push_back(at_day(31, 0));
    directed.push_back(at_day(58, 43210));
    directed.push_back(at_day(59, 0));
    directed.push_back(at_day(364, 86399));
    directed.push_back(at_day(365, 0));
    directed.push_back(at_day(first_day(1972, 2) + 28, 86399));
    directed.push_back(at_day(first_day(1973, 1) - 1, 86399));
    directed.push_back(at_day(first_day(2000, 2) + 28, 12345));
    directed.push_back(at_day(first_day(2001, 1) - 1, 0));
    directed.push_back(at_day(first_day(2100, 2) + 27, 86399));
    directed.push_back(at_day(first_day(2100, 3), 0));
    directed.push_back(at_day(first_day(2106, 1) - 1, 86399));
    directed.push_back(32'h7FFF_FFFF);
    directed.push_back(32'h8000_0000);
    directed.push_back(32'hFFFF_FFFF);
    directed.push_back(32'hAAAA_AAAA);
    directed.push_back(32'h5555_5555);
    foreach (directed[i]) send_seconds(directed[i]);

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n % 400) >= 320;
      send_seconds(random_seconds());
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (dates.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (dates.errors == 0 && dates.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
